>>> design/ohms_pkg.sv
// Shared types, register codes and helpers for the Ohm's law field stencil.
// Used by ohms_cfg_regs, ohms_divider and the top level; depends on nothing.
`default_nettype none

package ohms_pkg;

  localparam int DW = 32;
  localparam int ROW_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_FLOOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALL_X_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALL_Y_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAPER_SPAN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd6;

  localparam int MODE_HALL = 0;
  localparam int MODE_TAPER = 1;
  localparam int MODE_SMOOTH = 2;

  localparam logic [2:0] OP_CONV_X = 3'd0;
  localparam logic [2:0] OP_CONV_Y = 3'd1;
  localparam logic [2:0] OP_HALL_X = 3'd2;
  localparam logic [2:0] OP_HALL_Y = 3'd3;
  localparam logic [2:0] OP_TAPER_X = 3'd4;
  localparam logic [2:0] OP_TAPER_Y = 3'd5;

  typedef struct packed {
    logic [30:0] charge_floor;
    logic [30:0] hall_x_gain;
    logic [30:0] hall_y_gain;
    logic [2:0]  mode_flags;
    logic [7:0]  taper_span;
    logic [10:0] grid_columns;
    logic [15:0] grid_rows;
  } cfg_t;

  typedef struct packed {
    logic signed [DW-1:0] qa;
    logic signed [DW-1:0] qb;
    logic signed [DW-1:0] ba;
    logic signed [DW-1:0] bb;
    logic signed [DW-1:0] jx;
    logic signed [DW-1:0] jy;
  } line_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [DW-1:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -hi - 65'sd1;
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[DW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/ohms_cfg_regs.sv
// Configuration register bank of the Ohm's law field stencil.
// Depends on ohms_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module ohms_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ohms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data,
  output ohms_pkg::cfg_t                       cfg
);

  ohms_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charge_floor <= 31'd1;
      cfg_r.hall_x_gain <= 31'd65536;
      cfg_r.hall_y_gain <= 31'd65536;
      cfg_r.mode_flags <= 3'd0;
      cfg_r.taper_span <= 8'd4;
      cfg_r.grid_columns <= 11'd1024;
      cfg_r.grid_rows <= 16'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ohms_pkg::REG_CHARGE_FLOOR: cfg_r.charge_floor <= cfg_data[30:0];
        ohms_pkg::REG_HALL_X_GAIN:  cfg_r.hall_x_gain <= cfg_data[30:0];
        ohms_pkg::REG_HALL_Y_GAIN:  cfg_r.hall_y_gain <= cfg_data[30:0];
        ohms_pkg::REG_MODE_FLAGS:   cfg_r.mode_flags <= cfg_data[2:0];
        ohms_pkg::REG_TAPER_SPAN:   cfg_r.taper_span <= cfg_data[7:0];
        ohms_pkg::REG_GRID_COLUMNS: cfg_r.grid_columns <= cfg_data[10:0];
        ohms_pkg::REG_GRID_ROWS:    cfg_r.grid_rows <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/ohms_line_mem.sv
// Line buffer memory: one write port and one read port, registered read data.
// Holds the packed row history of every column; depends on nothing.
`default_nettype none

module ohms_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/ohms_divider.sv
// Iterative restoring divider, 64-bit magnitude by 32-bit divisor, one bit per cycle.
// Depends on ohms_pkg for the div_stat_t status bundle.
`default_nettype none

module ohms_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] numer,
  input  wire logic [31:0] denom,
  output ohms_pkg::div_stat_t stat,
  output logic [63:0]      quot
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [63:0] quo_r;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem_r, quo_r[63]};
  assign fits = shifted >= {1'b0, den_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      den_r <= denom;
      quo_r <= numer;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= 32'(shifted - {1'b0, den_r});
      end else begin
        rem_r <= shifted[31:0];
      end
      quo_r <= {quo_r[62:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> design/ohms_law_field_stencil.sv
// Top level of the Ohm's law field stencil: sequencer, multiplier and output register.
// Depends on ohms_pkg, ohms_cfg_regs, ohms_line_mem and ohms_divider.
//
//   Port group | Direction | Handshake          | Payload
//   in_        | input     | in_valid/in_stall  | current_x, current_y, magnetic_z, charge
//   out_       | output    | out_valid/out_stall| field_x, field_y, column, row, frame_end
//   cfg_       | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One cell is worked at a time. An interior cell takes 2 to 6 passes through the
// shared 64-step divider. Reset is synchronous and needs no clearing pass.
// A result waits in the output register while the next cell is worked; only the
// final write of a cell waits for a stalled output to drain.
`default_nettype none

module ohms_law_field_stencil #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [31:0]                   in_current_x,
  input  wire logic signed [31:0]                   in_current_y,
  input  wire logic signed [31:0]                   in_magnetic_z,
  input  wire logic signed [31:0]                   in_charge,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [31:0]                        out_field_x,
  output logic signed [31:0]                        out_field_y,
  output logic [$clog2(MAX_COLUMNS)-1:0]            out_column,
  output logic [15:0]                               out_row,
  output logic                                      out_frame_end,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ohms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                          cfg_data
);

  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int CW = AW + 1;
  localparam int LW = $bits(ohms_pkg::line_word_t);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_C, ST_RD_N, ST_GET_N, ST_PREP, ST_MUL,
    ST_DIV_GO, ST_DIV_WAIT, ST_SUM, ST_WRITE
  } state_t;

  ohms_pkg::cfg_t      cfg;
  ohms_pkg::div_stat_t div_stat;
  ohms_pkg::line_word_t w_c_r;
  ohms_pkg::line_word_t wr_word;

  state_t         state_r;
  logic [2:0]     op_r;
  logic [AW-1:0]  col_cnt_r;
  logic [15:0]    row_cnt_r;
  logic signed [31:0] left_q_r;
  logic signed [31:0] left_b_r;
  logic           out_valid_r;

  logic [AW-1:0]  c_r;
  logic [15:0]    r_r;
  logic signed [31:0] jx_in_r, jy_in_r, bz_in_r, q_in_r;
  logic signed [31:0] qa1_r, ba1_r;
  logic [31:0]    qs_r;
  logic signed [32:0] dbx_r, dby_r;
  logic [7:0]     d_r;
  logic           taper_on_r;
  logic           emit_r;
  logic signed [63:0] num_r;
  logic           neg_r;
  logic signed [31:0] cx_r, cy_r, hx_r, hy_r, fx_r, fy_r;
  logic signed [31:0] out_fx_r, out_fy_r;
  logic [AW-1:0]  out_col_r;
  logic [15:0]    out_row_r;
  logic           out_fe_r;

  logic [31:0]    gc32, cols32;
  logic [CW-1:0]  cols_eff;
  logic [15:0]    rows_eff;
  logic           col_wrap;
  logic [AW-1:0]  c_acc;
  logic [16:0]    r_inc;
  logic [15:0]    r_acc;
  logic           in_acc;

  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [LW-1:0]  mem_rdata;
  logic           mem_we;
  ohms_pkg::line_word_t rd_word;

  logic signed [34:0] smooth_sum, smooth_q, mag35;
  logic [31:0]    mag32, fl32, qs_nxt;
  logic [15:0]    er;
  logic           interior;
  logic [16:0]    t_left, t_right, t_top, t_bot, d01, d23, dmin;
  logic           taper_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic           mul_neg;
  logic [63:0]    num_mag;
  logic [31:0]    div_den;
  logic           div_start;
  logic [63:0]    quot;
  logic signed [64:0] q_signed;
  logic [31:0]    q_sat;
  logic           write_go;
  logic           out_load;
  logic [CW-1:0]  c_next;
  logic [16:0]    r_next;

  ohms_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  ohms_line_mem #(.DEPTH(MAX_COLUMNS), .WIDTH(LW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(c_r), .wdata(wr_word),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  ohms_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .numer(num_mag), .denom(div_den),
    .stat(div_stat), .quot(quot)
  );

  assign rd_word = ohms_pkg::line_word_t'(mem_rdata);

  // Effective grid size and the column and row of the arriving cell.
  assign gc32 = 32'(cfg.grid_columns);
  assign cols32 = (gc32 < 32'd3) ? 32'd3 :
                  (gc32 > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : gc32;
  assign cols_eff = cols32[CW-1:0];
  assign rows_eff = (cfg.grid_rows < 16'd3) ? 16'd3 : cfg.grid_rows;
  assign col_wrap = CW'(col_cnt_r) >= cols_eff;
  assign c_acc = col_wrap ? '0 : col_cnt_r;
  assign r_inc = col_wrap ? ({1'b0, row_cnt_r} + 17'd1) : {1'b0, row_cnt_r};
  assign r_acc = (r_inc >= {1'b0, rows_eff}) ? 16'd0 : r_inc[15:0];

  assign in_stall = state_r != ST_IDLE;
  assign in_acc = in_valid && !in_stall;

  assign mem_re = (state_r == ST_RD_C) || (state_r == ST_RD_N);
  assign mem_raddr = (state_r == ST_RD_N) ? (c_r + AW'(1)) : c_r;

  // Charge at the emitted cell, smoothed if enabled, then floored.
  assign smooth_sum = $signed({w_c_r.qa[31], w_c_r.qa, 2'b00})
                    + $signed({{3{left_q_r[31]}}, left_q_r})
                    + $signed({{3{qa1_r[31]}}, qa1_r})
                    + $signed({{3{w_c_r.qb[31]}}, w_c_r.qb})
                    + $signed({{3{q_in_r[31]}}, q_in_r});
  assign smooth_q = cfg.mode_flags[ohms_pkg::MODE_SMOOTH] ? (smooth_sum >>> 3)
                    : $signed({{3{w_c_r.qa[31]}}, w_c_r.qa});
  assign mag35 = smooth_q[34] ? -smooth_q : smooth_q;
  assign mag32 = mag35[31:0];
  assign fl32 = (cfg.charge_floor == 31'd0) ? 32'd1 : {1'b0, cfg.charge_floor};
  assign qs_nxt = (mag32 > fl32) ? mag32 : fl32;

  assign er = r_r - 16'd1;
  assign interior = (r_r >= 16'd2) && (c_r != '0) && ((CW'(c_r) + CW'(2)) <= cols_eff);

  assign t_left = 17'(c_r);
  assign t_right = 17'(cols_eff) - 17'd1 - 17'(c_r);
  assign t_top = {1'b0, er};
  assign t_bot = {1'b0, rows_eff} - 17'd1 - {1'b0, er};
  assign d01 = (t_right < t_left) ? t_right : t_left;
  assign d23 = (t_bot < t_top) ? t_bot : t_top;
  assign dmin = (d23 < d01) ? d23 : d01;
  assign taper_nxt = cfg.mode_flags[ohms_pkg::MODE_TAPER] && (cfg.taper_span != 8'd0)
                     && (dmin < {9'd0, cfg.taper_span});

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_neg = 1'b0;
    case (op_r)
      ohms_pkg::OP_CONV_X: begin
        mul_a = {w_c_r.jy[31], w_c_r.jy};
        mul_b = {w_c_r.ba[31], w_c_r.ba};
        mul_neg = 1'b1;
      end
      ohms_pkg::OP_CONV_Y: begin
        mul_a = {w_c_r.jx[31], w_c_r.jx};
        mul_b = {w_c_r.ba[31], w_c_r.ba};
      end
      ohms_pkg::OP_HALL_X: begin
        mul_a = dbx_r;
        mul_b = $signed({2'b00, cfg.hall_x_gain});
        mul_neg = 1'b1;
      end
      ohms_pkg::OP_HALL_Y: begin
        mul_a = dby_r;
        mul_b = $signed({2'b00, cfg.hall_y_gain});
        mul_neg = 1'b1;
      end
      ohms_pkg::OP_TAPER_X: begin
        mul_a = {hx_r[31], hx_r};
        mul_b = $signed({25'd0, d_r});
      end
      ohms_pkg::OP_TAPER_Y: begin
        mul_a = {hy_r[31], hy_r};
        mul_b = $signed({25'd0, d_r});
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign num_mag = num_r[63] ? 64'(-num_r) : 64'(num_r);
  assign div_den = (op_r == ohms_pkg::OP_TAPER_X || op_r == ohms_pkg::OP_TAPER_Y)
                   ? {24'd0, cfg.taper_span} : qs_r;
  assign div_start = state_r == ST_DIV_GO;
  assign q_signed = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign q_sat = ohms_pkg::sat32(q_signed);

  assign out_load = emit_r;
  assign write_go = (state_r == ST_WRITE) && !(emit_r && out_valid_r && out_stall);
  assign mem_we = write_go;

  assign wr_word.qa = q_in_r;
  assign wr_word.qb = w_c_r.qa;
  assign wr_word.ba = bz_in_r;
  assign wr_word.bb = w_c_r.ba;
  assign wr_word.jx = jx_in_r;
  assign wr_word.jy = jy_in_r;

  assign c_next = CW'(c_r) + CW'(1);
  assign r_next = {1'b0, r_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= ohms_pkg::OP_CONV_X;
      col_cnt_r <= '0;
      row_cnt_r <= 16'd0;
      left_q_r <= 32'sd0;
      left_b_r <= 32'sd0;
      out_valid_r <= 1'b0;
    end else begin
      if (write_go && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_RD_C;
          end
        end
        ST_RD_C:  state_r <= ST_RD_N;
        ST_RD_N:  state_r <= ST_GET_N;
        ST_GET_N: state_r <= ST_PREP;
        ST_PREP: begin
          op_r <= ohms_pkg::OP_CONV_X;
          state_r <= (emit_r && interior) ? ST_MUL : ST_WRITE;
        end
        ST_MUL:     state_r <= ST_DIV_GO;
        ST_DIV_GO:  state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            state_r <= ST_MUL;
            op_r <= op_r + 3'd1;
            if (op_r == ohms_pkg::OP_CONV_Y && !cfg.mode_flags[ohms_pkg::MODE_HALL]) begin
              state_r <= ST_SUM;
            end else if (op_r == ohms_pkg::OP_HALL_Y && !taper_on_r) begin
              state_r <= ST_SUM;
            end else if (op_r == ohms_pkg::OP_TAPER_Y) begin
              state_r <= ST_SUM;
            end
          end
        end
        ST_SUM: state_r <= ST_WRITE;
        ST_WRITE: begin
          if (write_go) begin
            state_r <= ST_IDLE;
            left_q_r <= w_c_r.qa;
            left_b_r <= w_c_r.ba;
            if (c_next >= cols_eff) begin
              col_cnt_r <= '0;
              row_cnt_r <= (r_next >= {1'b0, rows_eff}) ? 16'd0 : r_next[15:0];
            end else begin
              col_cnt_r <= c_next[AW-1:0];
              row_cnt_r <= r_r;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_r <= c_acc;
      r_r <= r_acc;
      jx_in_r <= in_current_x;
      jy_in_r <= in_current_y;
      bz_in_r <= in_magnetic_z;
      q_in_r <= in_charge;
      emit_r <= r_acc != 16'd0;
    end
    if (state_r == ST_RD_N) begin
      w_c_r <= rd_word;
    end
    if (state_r == ST_GET_N) begin
      qa1_r <= rd_word.qa;
      ba1_r <= rd_word.ba;
    end
    if (state_r == ST_PREP) begin
      qs_r <= qs_nxt;
      dbx_r <= $signed({ba1_r[31], ba1_r}) - $signed({left_b_r[31], left_b_r});
      dby_r <= $signed({bz_in_r[31], bz_in_r}) - $signed({w_c_r.bb[31], w_c_r.bb});
      d_r <= dmin[7:0];
      taper_on_r <= taper_nxt;
      cx_r <= 32'sd0;
      cy_r <= 32'sd0;
      hx_r <= 32'sd0;
      hy_r <= 32'sd0;
      fx_r <= 32'sd0;
      fy_r <= 32'sd0;
    end
    if (state_r == ST_MUL) begin
      num_r <= mul_neg ? -mul_p[63:0] : mul_p[63:0];
    end
    if (state_r == ST_DIV_GO) begin
      neg_r <= num_r[63];
    end
    if (state_r == ST_DIV_WAIT && div_stat.done) begin
      case (op_r)
        ohms_pkg::OP_CONV_X: cx_r <= q_sat;
        ohms_pkg::OP_CONV_Y: cy_r <= q_sat;
        ohms_pkg::OP_HALL_X, ohms_pkg::OP_TAPER_X: hx_r <= q_sat;
        ohms_pkg::OP_HALL_Y, ohms_pkg::OP_TAPER_Y: hy_r <= q_sat;
        default: begin
        end
      endcase
    end
    if (state_r == ST_SUM) begin
      fx_r <= ohms_pkg::sat32(65'(cx_r) + 65'(hx_r));
      fy_r <= ohms_pkg::sat32(65'(cy_r) + 65'(hy_r));
    end
    if (write_go && out_load) begin
      out_fx_r <= fx_r;
      out_fy_r <= fy_r;
      out_col_r <= c_r;
      out_row_r <= er;
      out_fe_r <= (r_next == {1'b0, rows_eff}) && (c_next == cols_eff);
    end
  end

  assign out_valid = out_valid_r;
  assign out_field_x = out_fx_r;
  assign out_field_y = out_fy_r;
  assign out_column = out_col_r;
  assign out_row = out_row_r;
  assign out_frame_end = out_fe_r;

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_RD_C) else $error("accepted cell did not start its read");

  a_write_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> state_r == ST_IDLE) else $error("line write not followed by idle");

  a_div_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV_WAIT) else $error("divider busy outside wait");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (write_go && out_load) |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
